/* src/assert_macros.svh */
// Assertion macros used by the top level to check the FIR chain.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TSFIR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define TSFIR_ASSERT_IMP(label, ante, cons, msg) \
	`TSFIR_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* src/tsfir_pkg.sv */
// Constants, types, coefficient tables and arithmetic helpers of the FIR chain.
`default_nettype none

package tsfir_pkg;

	localparam int CHANNELS     = 10;
	localparam int TAPS         = 31;
	localparam int SAMPLE_WIDTH = 32;
	localparam int COEF_W       = 16;
	localparam int COEF_FRAC    = 15;
	localparam int CH_W         = 4;
	localparam int IO_W         = 32;
	localparam int CH_AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TREE_LVLS    = $clog2(TAPS);
	localparam int TREE_N       = 1 << TREE_LVLS;
	localparam int PROD_W       = SAMPLE_WIDTH + COEF_W;
	localparam int ACC_W        = PROD_W + TREE_LVLS;
	localparam int ROW_W        = TAPS * SAMPLE_WIDTH;
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = $clog2(Q_DEPTH);
	localparam int OUT_DEPTH    = 32;
	localparam int OB_AW        = $clog2(OUT_DEPTH);

	typedef logic [CH_W-1:0]                ch_t;
	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [IO_W-1:0]         io_t;
	typedef logic signed [COEF_W-1:0]       coef_t;
	typedef logic signed [PROD_W-1:0]       prod_t;
	typedef logic signed [ACC_W-1:0]        acc_t;
	typedef sample_t [TAPS-1:0]             row_t;
	typedef coef_t                          coef_tab_t [TAPS];

	// Item as it waits between the front and the back.
	typedef struct packed {
		logic    inr;
		ch_t     ch;
		sample_t x;
	} work_t;

	typedef struct packed {
		logic  vld;
		work_t item;
	} work_hs_t;

	typedef struct packed {
		logic vld;
		logic inr;
		ch_t  ch;
	} stage_ctl_t;

	typedef struct packed {
		logic    vld;
		logic    inr;
		ch_t     ch;
		sample_t x;
	} stage_io_t;

	typedef struct packed {
		ch_t ch;
		io_t value;
	} res_t;

	// Q1.15 taps, index 0 weights the newest sample.
	localparam coef_tab_t LP_TAPS = '{
		-16'sd56, -16'sd95, -16'sd125, -16'sd102, 16'sd0,
		16'sd226, 16'sd596, 16'sd1075, 16'sd1596, 16'sd2074,
		16'sd2422, 16'sd2572, 16'sd2487, 16'sd2176, 16'sd1691,
		16'sd1130, 16'sd593, 16'sd174, -16'sd72, -16'sd144,
		-16'sd102, 16'sd0, 16'sd102, 16'sd144, 16'sd72,
		-16'sd174, -16'sd593, -16'sd1130, -16'sd1691, -16'sd2176,
		-16'sd2487
	};

	localparam coef_tab_t HP_TAPS = '{
		-16'sd52, -16'sd66, -16'sd95, -16'sd144, -16'sd216,
		-16'sd308, -16'sd416, -16'sd541, -16'sd675, -16'sd809,
		-16'sd944, -16'sd1065, -16'sd1167, -16'sd1242, -16'sd1291,
		16'sd31408, -16'sd1291, -16'sd1242, -16'sd1167, -16'sd1065,
		-16'sd944, -16'sd809, -16'sd675, -16'sd541, -16'sd416,
		-16'sd308, -16'sd216, -16'sd144, -16'sd95, -16'sd66,
		-16'sd52
	};

	localparam coef_tab_t NT_TAPS = '{
		-16'sd43, -16'sd29, -16'sd13, 16'sd20, 16'sd82,
		16'sd164, 16'sd252, 16'sd321, 16'sd338, 16'sd285,
		16'sd157, -16'sd36, -16'sd256, -16'sd462, -16'sd609,
		16'sd32434, -16'sd609, -16'sd462, -16'sd256, -16'sd36,
		16'sd157, 16'sd285, 16'sd338, 16'sd321, 16'sd252,
		16'sd164, 16'sd82, 16'sd20, -16'sd13, -16'sd29,
		-16'sd43
	};

	// Clamp a wide signed value into the sample range.
	function automatic sample_t sat_sample(input acc_t v);
		logic [ACC_W-SAMPLE_WIDTH:0] top;
		sample_t r;
		top = v[ACC_W-1:SAMPLE_WIDTH-1];
		if ((&top) || !(|top)) begin
			r = v[SAMPLE_WIDTH-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic acc_t mul_tap(input sample_t a, input coef_t b);
		prod_t p;
		p = a * b;
		return acc_t'(p);
	endfunction

	// Drop the coefficient fraction with floor rounding, then clamp.
	function automatic sample_t stage_result(input acc_t v);
		acc_t s;
		s = v >>> COEF_FRAC;
		return sat_sample(s);
	endfunction

endpackage

`default_nettype wire

/* src/tsfir_in_if.sv */
// Input channel of the FIR chain: channel index and raw sample.
`default_nettype none

interface tsfir_in_if;
	logic                   valid;
	logic                   ready;
	tsfir_pkg::ch_t         channel;
	logic signed [31:0]     sample_in;

	modport source (output valid, output channel, output sample_in, input ready);
	modport sink (input valid, input channel, input sample_in, output ready);
endinterface

`default_nettype wire

/* src/tsfir_out_if.sv */
// Output channel of the FIR chain: channel index and filtered sample.
`default_nettype none

interface tsfir_out_if;
	logic                   valid;
	logic                   ready;
	tsfir_pkg::ch_t         channel_out;
	logic signed [31:0]     filtered;

	modport source (output valid, output channel_out, output filtered, input ready);
	modport sink (input valid, input channel_out, input filtered, output ready);
endinterface

`default_nettype wire

/* src/tsfir_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tsfir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/tsfir_front.sv */
// Front end: classifies the channel and clamps the raw sample into range.
`default_nettype none

module tsfir_front (
	tsfir_in_if.sink              din,
	output tsfir_pkg::work_hs_t   push,
	input  logic                  push_rdy
);

	assign din.ready       = push_rdy;
	assign push.vld        = din.valid;
	assign push.item.inr   = int'(din.channel) < tsfir_pkg::CHANNELS;
	assign push.item.ch    = din.channel;
	assign push.item.x     = tsfir_pkg::sat_sample(tsfir_pkg::acc_t'(din.sample_in));

endmodule

`default_nettype wire

/* src/tsfir_queue.sv */
// Short queue that decouples the front end from the filter pipeline.
`default_nettype none

module tsfir_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsfir_pkg::work_hs_t   push,
	output logic                  push_rdy,
	output tsfir_pkg::work_hs_t   pop,
	input  logic                  pop_rdy
);

	tsfir_pkg::work_t           mem_q [tsfir_pkg::Q_DEPTH];
	logic [tsfir_pkg::Q_AW:0]   wr_q;
	logic [tsfir_pkg::Q_AW:0]   rd_q;
	logic                       push_fire;
	logic                       pop_fire;

	// Pointers carry one extra bit so that full and empty differ.
	assign push_rdy = !((wr_q[tsfir_pkg::Q_AW] != rd_q[tsfir_pkg::Q_AW]) &&
		(wr_q[tsfir_pkg::Q_AW-1:0] == rd_q[tsfir_pkg::Q_AW-1:0]));
	assign pop.vld  = wr_q != rd_q;
	assign pop.item = mem_q[rd_q[tsfir_pkg::Q_AW-1:0]];

	assign push_fire = push.vld && push_rdy;
	assign pop_fire  = pop.vld && pop_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push_fire) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_q[tsfir_pkg::Q_AW-1:0]] <= push.item;
		end
	end

endmodule

`default_nettype wire

/* src/tsfir_stage.sv */
// One 31-tap FIR stage with per-channel delay lines held in a RAM row.
`default_nettype none

module tsfir_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tsfir_pkg::coef_tab_t   coefs,
	input  tsfir_pkg::stage_io_t   din,
	output tsfir_pkg::stage_io_t   dout
);

	tsfir_pkg::stage_ctl_t              ctl_s1;
	tsfir_pkg::stage_ctl_t              ctl_s2;
	tsfir_pkg::stage_ctl_t              ctl_s3;
	tsfir_pkg::stage_ctl_t              tctl_s4 [tsfir_pkg::TREE_LVLS];
	tsfir_pkg::stage_ctl_t              ctl_s9;
	tsfir_pkg::sample_t                 x_s1;
	tsfir_pkg::sample_t                 y_s9;
	tsfir_pkg::row_t                    rd_row;
	tsfir_pkg::row_t                    old_row;
	tsfir_pkg::row_t                    new_row;
	tsfir_pkg::row_t                    row_s2;
	tsfir_pkg::acc_t                    prod_s3 [tsfir_pkg::TREE_N];
	tsfir_pkg::acc_t                    sum_s4 [tsfir_pkg::TREE_LVLS][tsfir_pkg::TREE_N/2];
	logic [tsfir_pkg::CHANNELS-1:0]     row_vld_q;
	logic [tsfir_pkg::CH_AW-1:0]        rd_addr;
	logic [tsfir_pkg::CH_AW-1:0]        wr_addr;
	logic                               wr_en;
	logic                               bypass;

	assign rd_addr = tsfir_pkg::CH_AW'(din.ch);
	assign wr_addr = tsfir_pkg::CH_AW'(ctl_s1.ch);
	assign wr_en   = ctl_s1.vld && ctl_s1.inr;

	tsfir_ram #(
		.WIDTH(tsfir_pkg::ROW_W),
		.DEPTH(tsfir_pkg::CHANNELS)
	) u_hist_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (new_row),
		.raddr (rd_addr),
		.rdata (rd_row)
	);

	// The RAM read for an item misses the write of the item just ahead of it,
	// so that row is taken from the stage-2 register instead.
	assign bypass = ctl_s2.vld && ctl_s2.inr && (ctl_s2.ch == ctl_s1.ch);

	always_comb begin
		priority if (!ctl_s1.inr) begin
			old_row = '0;
		end else if (bypass) begin
			old_row = row_s2;
		end else if (row_vld_q[wr_addr]) begin
			old_row = rd_row;
		end else begin
			old_row = '0;
		end
	end

	always_comb begin
		new_row[0] = x_s1;
		for (int i = 1; i < tsfir_pkg::TAPS; i++) begin
			new_row[i] = old_row[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			ctl_s9    <= '0;
			row_vld_q <= '0;
			for (int l = 0; l < tsfir_pkg::TREE_LVLS; l++) begin
				tctl_s4[l] <= '0;
			end
		end else begin
			ctl_s1 <= '{vld: din.vld, inr: din.inr, ch: din.ch};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			tctl_s4[0] <= ctl_s3;
			for (int l = 1; l < tsfir_pkg::TREE_LVLS; l++) begin
				tctl_s4[l] <= tctl_s4[l-1];
			end
			ctl_s9 <= tctl_s4[tsfir_pkg::TREE_LVLS-1];
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Products, then a registered adder tree padded with zeros to a power of two.
	always_ff @(posedge clk) begin
		x_s1   <= din.x;
		row_s2 <= new_row;
		for (int i = 0; i < tsfir_pkg::TREE_N; i++) begin
			if (i < tsfir_pkg::TAPS) begin
				prod_s3[i] <= tsfir_pkg::mul_tap(row_s2[i], coefs[i]);
			end else begin
				prod_s3[i] <= '0;
			end
		end
		for (int l = 0; l < tsfir_pkg::TREE_LVLS; l++) begin
			for (int j = 0; j < tsfir_pkg::TREE_N / 2; j++) begin
				if (j < (tsfir_pkg::TREE_N >> (l + 1))) begin
					if (l == 0) begin
						sum_s4[l][j] <= prod_s3[2*j] + prod_s3[2*j+1];
					end else begin
						sum_s4[l][j] <= sum_s4[l-1][2*j] + sum_s4[l-1][2*j+1];
					end
				end else begin
					sum_s4[l][j] <= '0;
				end
			end
		end
		y_s9 <= tsfir_pkg::stage_result(sum_s4[tsfir_pkg::TREE_LVLS-1][0]);
	end

	assign dout = '{vld: ctl_s9.vld, inr: ctl_s9.inr, ch: ctl_s9.ch, x: y_s9};

endmodule

`default_nettype wire

/* src/tsfir_back.sv */
// Back end: three chained FIR stages, result buffer and issue credits.
`default_nettype none

module tsfir_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsfir_pkg::work_hs_t   pop,
	output logic                  pop_rdy,
	tsfir_out_if.source           dout
);

	localparam int CNT_W = $clog2(tsfir_pkg::OUT_DEPTH + 1);

	tsfir_pkg::stage_io_t        st_io [4];
	tsfir_pkg::res_t             ob_q [tsfir_pkg::OUT_DEPTH];
	tsfir_pkg::res_t             ob_wdata;
	logic [tsfir_pkg::OB_AW:0]   ob_wr_q;
	logic [tsfir_pkg::OB_AW:0]   ob_rd_q;
	logic [CNT_W-1:0]            credit_q;
	logic                        credit_ok;
	logic                        issue;
	logic                        ob_pop;

	// Every issued item owns a buffer slot until it is taken at the output,
	// so the pipeline never has to stall.
	assign credit_ok = credit_q < CNT_W'(tsfir_pkg::OUT_DEPTH);
	assign pop_rdy   = credit_ok;
	assign issue     = pop.vld && credit_ok;
	assign ob_pop    = dout.valid && dout.ready;

	assign st_io[0] = '{vld: issue, inr: pop.item.inr, ch: pop.item.ch, x: pop.item.x};

	tsfir_stage u_lowpass (
		.clk    (clk),
		.arst_n (arst_n),
		.coefs  (tsfir_pkg::LP_TAPS),
		.din    (st_io[0]),
		.dout   (st_io[1])
	);

	tsfir_stage u_highpass (
		.clk    (clk),
		.arst_n (arst_n),
		.coefs  (tsfir_pkg::HP_TAPS),
		.din    (st_io[1]),
		.dout   (st_io[2])
	);

	tsfir_stage u_notch (
		.clk    (clk),
		.arst_n (arst_n),
		.coefs  (tsfir_pkg::NT_TAPS),
		.din    (st_io[2]),
		.dout   (st_io[3])
	);

	// An out-of-range channel left every history alone and reports zero.
	assign ob_wdata.ch    = st_io[3].ch;
	assign ob_wdata.value = st_io[3].inr ? tsfir_pkg::IO_W'(st_io[3].x) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			ob_wr_q  <= '0;
			ob_rd_q  <= '0;
		end else begin
			if (issue && !ob_pop) begin
				credit_q <= credit_q + 1'b1;
			end else if (!issue && ob_pop) begin
				credit_q <= credit_q - 1'b1;
			end
			if (st_io[3].vld) begin
				ob_wr_q <= ob_wr_q + 1'b1;
			end
			if (ob_pop) begin
				ob_rd_q <= ob_rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_io[3].vld) begin
			ob_q[ob_wr_q[tsfir_pkg::OB_AW-1:0]] <= ob_wdata;
		end
	end

	assign dout.valid       = ob_wr_q != ob_rd_q;
	assign dout.channel_out = ob_q[ob_rd_q[tsfir_pkg::OB_AW-1:0]].ch;
	assign dout.filtered    = ob_q[ob_rd_q[tsfir_pkg::OB_AW-1:0]].value;

endmodule

`default_nettype wire

/* src/three_stage_multichannel_fir_chain.sv */
// Top level of the three-stage multichannel FIR chain.
`default_nettype none
`include "assert_macros.svh"

// Each item carries a Q16.16 sample and its channel (0 to 9); the sample runs
// through that channel's low-pass, high-pass and notch filters (31 taps each,
// Q1.15 taps, exact accumulation, floor shift and saturation after every
// stage) and exactly one result comes back per item, in order. An item with a
// channel of 10 or more changes no history and returns zero. The block takes
// one item per clock, sustained, on any mix of channels, including the same
// channel back to back. An accepted item passes through a 4-entry input
// queue, then nine pipeline registers per filter (history read, line shift,
// products, a five-level adder tree, rounding), then a 32-entry result
// buffer. Input is stalled only once 32 items are inside the filters or
// waiting in that buffer and four more have filled the queue behind them.
// Each filter keeps its per-channel delay lines as one RAM row per channel;
// a per-channel valid bit makes a line read as zero until its first write,
// so no clearing pass follows reset.
module three_stage_multichannel_fir_chain (
	input  logic          clk,
	input  logic          arst_n,
	tsfir_in_if.sink      din,
	tsfir_out_if.source   dout
);

	localparam int LIVE_MAX = tsfir_pkg::Q_DEPTH + tsfir_pkg::OUT_DEPTH;
	localparam int LIVE_W   = $clog2(LIVE_MAX + 1);

	tsfir_pkg::work_hs_t   q_push;
	tsfir_pkg::work_hs_t   q_pop;
	logic                  q_push_rdy;
	logic                  q_pop_rdy;
	logic [LIVE_W-1:0]     live_q;
	logic                  in_fire;
	logic                  out_fire;
	logic                  bad_ch_out;

	tsfir_front u_front (
		.din      (din),
		.push     (q_push),
		.push_rdy (q_push_rdy)
	);

	tsfir_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rdy (q_push_rdy),
		.pop      (q_pop),
		.pop_rdy  (q_pop_rdy)
	);

	tsfir_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop     (q_pop),
		.pop_rdy (q_pop_rdy),
		.dout    (dout)
	);

	// Items accepted whose results have not been taken yet.
	assign in_fire  = din.valid && din.ready;
	assign out_fire = dout.valid && dout.ready;

	assign bad_ch_out = dout.valid && (int'(dout.channel_out) >= tsfir_pkg::CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (in_fire && !out_fire) begin
			live_q <= live_q + 1'b1;
		end else if (!in_fire && out_fire) begin
			live_q <= live_q - 1'b1;
		end
	end

	`TSFIR_ASSERT_IMP(a_no_invented_result, dout.valid, live_q != '0, "result with no item pending")
	`TSFIR_ASSERT(a_occupancy_bound, live_q <= LIVE_W'(LIVE_MAX), "too many items inside")
	`TSFIR_ASSERT_IMP(a_bad_channel_zero, bad_ch_out, dout.filtered == '0, "bad channel gave nonzero")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the three-stage multichannel FIR chain.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef tsfir_pkg::ch_t ch_t;
	typedef tsfir_pkg::io_t io_t;

	localparam int NUM_CHANNELS = tsfir_pkg::CHANNELS;
	localparam int NUM_TAPS     = tsfir_pkg::TAPS;
	localparam int COEF_SHIFT   = 15;
	localparam int IDLE_PCT     = 28;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 64;
	localparam int STALL_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1600;

	localparam io_t   FULL_POS   = 32'sh7FFF_FFFF;
	localparam io_t   FULL_NEG   = 32'sh8000_0000;
	localparam io_t   ONE_Q16    = 32'sh0001_0000;
	localparam longint CLAMP_HI  = 64'sd2147483647;
	localparam longint CLAMP_LO  = -64'sd2147483648;

	localparam int LP_COEF [31] = '{
		-56, -95, -125, -102, 0, 226, 596, 1075, 1596, 2074,
		2422, 2572, 2487, 2176, 1691, 1130, 593, 174, -72, -144,
		-102, 0, 102, 144, 72, -174, -593, -1130, -1691, -2176,
		-2487
	};
	localparam int HP_COEF [31] = '{
		-52, -66, -95, -144, -216, -308, -416, -541, -675, -809,
		-944, -1065, -1167, -1242, -1291, 31408, -1291, -1242, -1167, -1065,
		-944, -809, -675, -541, -416, -308, -216, -144, -95, -66,
		-52
	};
	localparam int NT_COEF [31] = '{
		-43, -29, -13, 20, 82, 164, 252, 321, 338, 285,
		157, -36, -256, -462, -609, 32434, -609, -462, -256, -36,
		157, 285, 338, 321, 252, 164, 82, 20, -13, -29,
		-43
	};

	typedef enum int {LOWPASS, HIGHPASS, NOTCH} filt_e;

	typedef struct packed {
		ch_t ch;
		io_t value;
	} filt_result_t;

	logic clk = 1'b0;
	logic arst_n;

	tsfir_in_if  din_bus ();
	tsfir_out_if dout_bus ();

	three_stage_multichannel_fir_chain DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_bus),
		.dout   (dout_bus)
	);

	// Delay lines of the predictor, tap 0 newest.
	longint       filt_history [3][NUM_CHANNELS][NUM_TAPS];
	filt_result_t pending_filtered [$];
	int           error_count = 0;
	int           cycle_count = 0;
	bit           sender_idle_on = 1'b1;
	bit           receiver_idle_on = 1'b1;
	int           hold_request = 0;
	int           hold_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int tap_weight(filt_e f, int t);
		unique case (f)
			LOWPASS:  return LP_COEF[t];
			HIGHPASS: return HP_COEF[t];
			default:  return NT_COEF[t];
		endcase
	endfunction

	function automatic longint filter_stage(filt_e f, int ch, longint x);
		longint acc;
		acc = 0;
		for (int t = NUM_TAPS - 1; t > 0; t--) begin
			filt_history[f][ch][t] = filt_history[f][ch][t-1];
		end
		filt_history[f][ch][0] = x;
		for (int t = 0; t < NUM_TAPS; t++) begin
			acc += filt_history[f][ch][t] * longint'(tap_weight(f, t));
		end
		// Arithmetic shift of a signed value rounds toward minus infinity.
		acc = acc >>> COEF_SHIFT;
		if (acc > CLAMP_HI) begin
			acc = CLAMP_HI;
		end else if (acc < CLAMP_LO) begin
			acc = CLAMP_LO;
		end
		return acc;
	endfunction

	function automatic filt_result_t filter_chain_predict(ch_t ch, io_t s);
		filt_result_t r;
		longint x;
		r.ch = ch;
		r.value = '0;
		// Channels past the last one leave every history alone and return zero.
		if (ch < NUM_CHANNELS) begin
			x = longint'(s);
			x = filter_stage(LOWPASS, ch, x);
			x = filter_stage(HIGHPASS, ch, x);
			x = filter_stage(NOTCH, ch, x);
			r.value = io_t'(x);
		end
		return r;
	endfunction

	function automatic io_t rand_sample();
		unique case ($urandom_range(0, 9))
			0: return FULL_POS;
			1: return FULL_NEG;
			2, 3: return io_t'($urandom);
			4, 5, 6: return io_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			7: return $urandom_range(0, 1) ? ONE_Q16 : -ONE_Q16;
			default: return io_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
		endcase
	endfunction

	task automatic send_item(input ch_t ch, input io_t s);
		@(negedge clk);
		while (sender_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			din_bus.valid <= 1'b0;
			@(negedge clk);
		end
		din_bus.valid     <= 1'b1;
		din_bus.channel   <= ch;
		din_bus.sample_in <= s;
		do @(posedge clk); while (!din_bus.ready);
		pending_filtered.push_back(filter_chain_predict(ch, s));
	endtask

	task automatic release_input();
		@(negedge clk);
		din_bus.valid <= 1'b0;
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			dout_bus.ready <= 1'b0;
		end else begin
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_bus.ready <= 1'b0;
			end else begin
				dout_bus.ready <= !(receiver_idle_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout_bus.valid && dout_bus.ready) begin
			if (pending_filtered.size() == 0) begin
				$error("result with nothing expected: channel_out %0d, filtered %0d",
					dout_bus.channel_out, dout_bus.filtered);
				error_count++;
			end else begin
				if (dout_bus.channel_out !== pending_filtered[0].ch) begin
					$error("channel_out mismatch: expected %0d, actual %0d",
						pending_filtered[0].ch, dout_bus.channel_out);
					error_count++;
				end
				if (dout_bus.filtered !== pending_filtered[0].value) begin
					$error("filtered mismatch: expected %0d, actual %0d",
						pending_filtered[0].value, dout_bus.filtered);
					error_count++;
				end
				void'(pending_filtered.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// A few items on untouched channels, whose histories are still zero.
	task automatic test_fresh_channels();
		send_item(ch_t'(0), 32'sd0);
		send_item(ch_t'(9), 32'sd1);
		send_item(ch_t'(5), ONE_Q16);
	endtask

	task automatic test_sample_extremes();
		send_item(ch_t'(0), FULL_POS);
		send_item(ch_t'(0), FULL_NEG);
		send_item(ch_t'(9), FULL_NEG);
		send_item(ch_t'(9), FULL_POS);
		send_item(ch_t'(3), -32'sd1);
	endtask

	// Channels 10 to 15 must return zero and leave all histories untouched.
	task automatic test_out_of_range_channels();
		send_item(ch_t'(10), FULL_POS);
		send_item(ch_t'(11), FULL_NEG);
		send_item(ch_t'(12), io_t'($urandom));
		send_item(ch_t'(13), ONE_Q16);
		send_item(ch_t'(14), -32'sd1);
		send_item(ch_t'(15), FULL_NEG);
		send_item(ch_t'(9), ONE_Q16);
	endtask

	task automatic test_same_channel_burst();
		sender_idle_on = 1'b0;
		for (int i = 0; i < 8; i++) begin
			send_item(ch_t'(2), i[0] ? FULL_NEG : FULL_POS);
		end
		sender_idle_on = 1'b1;
	endtask

	// Hold the output back long enough that the block fills and stalls its input.
	task automatic test_output_stall();
		sender_idle_on = 1'b0;
		send_item(ch_t'($urandom_range(0, NUM_CHANNELS - 1)), rand_sample());
		hold_request = STALL_CYCLES;
		for (int i = 0; i < 80; i++) begin
			send_item(ch_t'($urandom_range(0, NUM_CHANNELS - 1)), rand_sample());
		end
		sender_idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int   in_range_sent;
		int   burst_left;
		ch_t  burst_ch;
		ch_t  ch;
		io_t  s;
		in_range_sent = 0;
		burst_left = 0;
		burst_ch = '0;
		while (in_range_sent < RANDOM_ITEMS) begin
			// A stretch in the middle runs with neither side idling.
			sender_idle_on   = !(in_range_sent >= 700 && in_range_sent < 1000);
			receiver_idle_on = sender_idle_on;
			if (burst_left == 0 && $urandom_range(0, 99) < 4) begin
				burst_left = $urandom_range(8, 40);
				burst_ch = ch_t'($urandom_range(0, NUM_CHANNELS - 1));
			end
			if (burst_left > 0) begin
				// Full-scale runs on one channel push the later stages into saturation.
				burst_left--;
				ch = burst_ch;
				s = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
			end else begin
				if ($urandom_range(0, 99) < 8) begin
					ch = ch_t'($urandom_range(NUM_CHANNELS, 15));
				end else begin
					ch = ch_t'($urandom_range(0, NUM_CHANNELS - 1));
				end
				s = rand_sample();
			end
			send_item(ch, s);
			if (ch < NUM_CHANNELS) begin
				in_range_sent++;
			end
		end
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		din_bus.valid = 1'b0;
		din_bus.channel = '0;
		din_bus.sample_in = '0;
		dout_bus.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_fresh_channels();
		test_sample_extremes();
		test_out_of_range_channels();
		test_same_channel_burst();
		test_output_stall();
		test_random_traffic();
		release_input();

		while (pending_filtered.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/tsfir_pkg.sv
src/tsfir_in_if.sv
src/tsfir_out_if.sv
src/tsfir_ram.sv
src/tsfir_front.sv
src/tsfir_queue.sv
src/tsfir_stage.sv
src/tsfir_back.sv
src/three_stage_multichannel_fir_chain.sv
dv/testbench.sv
